>>> design/rsch_pkg.sv
// Shared types, constants and the micro-step table of the closest-hit block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rsch_pkg;

    // Number format and table geometry
    localparam int FRAC_BITS     = 16;
    localparam int MAX_OBJECTS   = 64;
    localparam int WORDS_PER_OBJ = 10;
    localparam int MEM_DEPTH     = MAX_OBJECTS * WORDS_PER_OBJ;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int SLOT_IDX_W    = $clog2(MAX_OBJECTS);
    localparam int SCAN_W        = $clog2(MAX_OBJECTS + 1);
    localparam int FIDX_W        = $clog2(WORDS_PER_OBJ + 1);

    // Field widths
    localparam int WORD_W     = 32;
    localparam int DIST_W     = 31;
    localparam int SLOT_W     = 6;
    localparam int WIDX_W     = 4;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int ACC_W     = 2 * WORD_W - FRAC_BITS + 2;
    localparam int DIV_STEPS = DIST_W;
    localparam int SQ_STEPS  = (ACC_W + FRAC_BITS) / 2;
    localparam int ROOT_W    = SQ_STEPS;
    localparam int X_W       = 2 * SQ_STEPS;
    localparam int SREM_W    = ROOT_W + 3;
    localparam int T_W       = ROOT_W + 2;
    localparam int STEP_W    = $clog2((SQ_STEPS > DIV_STEPS) ? SQ_STEPS : DIV_STEPS);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Micro-step program
    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] UPC_TRI = 5'd0;
    localparam logic [UPC_W-1:0] UPC_SPH = 5'd24;

    // Request and object codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RAY  = 1'b1;
    localparam logic KIND_TRI = 1'b0;
    localparam logic KIND_SPH = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MHD   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_TVEC,
        ST_MUL,
        ST_ACC,
        ST_TRI_CHK,
        ST_DIV,
        ST_DCHK,
        ST_SQ_INIT,
        ST_SQRT,
        ST_SPH_CHK,
        ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        OPND_W0, OPND_W1, OPND_W2, OPND_W3, OPND_W4,
        OPND_W5, OPND_W6, OPND_W7, OPND_W8, OPND_W9,
        OPND_D0, OPND_D1, OPND_D2,
        OPND_T0, OPND_T1, OPND_T2,
        OPND_P0, OPND_P1, OPND_P2,
        OPND_Q0, OPND_Q1, OPND_Q2,
        OPND_B
    } opnd_t;

    typedef enum logic [1:0] {
        ACC_LOAD,
        ACC_NEG,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_P0, DST_P1, DST_P2,
        DST_Q0, DST_Q1, DST_Q2,
        DST_B,
        DST_DET, DST_UN, DST_VN, DST_TN,
        DST_DISC
    } dst_t;

    typedef struct packed {
        opnd_t   a;
        opnd_t   b;
        acc_op_t op;
        dst_t    dst;
        logic    last;
    } ustep_t;

    // Clamp a wide signed value to the signed word range
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi)
            return WORD_W'(hi);
        else if (v < lo)
            return WORD_W'(lo);
        return WORD_W'(v);
    endfunction

    // Triangle: cross(dir,e2), det, u, cross(t,e1), v, t. Sphere: b, discriminant.
    function automatic ustep_t ustep_rom(input logic [UPC_W-1:0] pc);
        ustep_t s;
        case (pc)
            5'd0:  s = '{OPND_D1, OPND_W8, ACC_LOAD, DST_NONE, 1'b0};
            5'd1:  s = '{OPND_D2, OPND_W7, ACC_SUB,  DST_P0,   1'b0};
            5'd2:  s = '{OPND_D2, OPND_W6, ACC_LOAD, DST_NONE, 1'b0};
            5'd3:  s = '{OPND_D0, OPND_W8, ACC_SUB,  DST_P1,   1'b0};
            5'd4:  s = '{OPND_D0, OPND_W7, ACC_LOAD, DST_NONE, 1'b0};
            5'd5:  s = '{OPND_D1, OPND_W6, ACC_SUB,  DST_P2,   1'b0};
            5'd6:  s = '{OPND_W3, OPND_P0, ACC_LOAD, DST_NONE, 1'b0};
            5'd7:  s = '{OPND_W4, OPND_P1, ACC_ADD,  DST_NONE, 1'b0};
            5'd8:  s = '{OPND_W5, OPND_P2, ACC_ADD,  DST_DET,  1'b0};
            5'd9:  s = '{OPND_T0, OPND_P0, ACC_LOAD, DST_NONE, 1'b0};
            5'd10: s = '{OPND_T1, OPND_P1, ACC_ADD,  DST_NONE, 1'b0};
            5'd11: s = '{OPND_T2, OPND_P2, ACC_ADD,  DST_UN,   1'b0};
            5'd12: s = '{OPND_T1, OPND_W5, ACC_LOAD, DST_NONE, 1'b0};
            5'd13: s = '{OPND_T2, OPND_W4, ACC_SUB,  DST_Q0,   1'b0};
            5'd14: s = '{OPND_T2, OPND_W3, ACC_LOAD, DST_NONE, 1'b0};
            5'd15: s = '{OPND_T0, OPND_W5, ACC_SUB,  DST_Q1,   1'b0};
            5'd16: s = '{OPND_T0, OPND_W4, ACC_LOAD, DST_NONE, 1'b0};
            5'd17: s = '{OPND_T1, OPND_W3, ACC_SUB,  DST_Q2,   1'b0};
            5'd18: s = '{OPND_D0, OPND_Q0, ACC_LOAD, DST_NONE, 1'b0};
            5'd19: s = '{OPND_D1, OPND_Q1, ACC_ADD,  DST_NONE, 1'b0};
            5'd20: s = '{OPND_D2, OPND_Q2, ACC_ADD,  DST_VN,   1'b0};
            5'd21: s = '{OPND_W6, OPND_Q0, ACC_LOAD, DST_NONE, 1'b0};
            5'd22: s = '{OPND_W7, OPND_Q1, ACC_ADD,  DST_NONE, 1'b0};
            5'd23: s = '{OPND_W8, OPND_Q2, ACC_ADD,  DST_TN,   1'b1};
            5'd24: s = '{OPND_T0, OPND_D0, ACC_NEG,  DST_NONE, 1'b0};
            5'd25: s = '{OPND_T1, OPND_D1, ACC_SUB,  DST_NONE, 1'b0};
            5'd26: s = '{OPND_T2, OPND_D2, ACC_SUB,  DST_B,    1'b0};
            5'd27: s = '{OPND_B,  OPND_B,  ACC_LOAD, DST_NONE, 1'b0};
            5'd28: s = '{OPND_T0, OPND_T0, ACC_SUB,  DST_NONE, 1'b0};
            5'd29: s = '{OPND_T1, OPND_T1, ACC_SUB,  DST_NONE, 1'b0};
            5'd30: s = '{OPND_T2, OPND_T2, ACC_SUB,  DST_NONE, 1'b0};
            5'd31: s = '{OPND_W9, OPND_W9, ACC_ADD,  DST_DISC, 1'b1};
            default: s = '{OPND_W0, OPND_W0, ACC_LOAD, DST_NONE, 1'b1};
        endcase
        return s;
    endfunction

endpackage

>>> design/rsch_if.sv
// Channel interfaces of the closest-hit block: request, result and register write.
// Depends on rsch_pkg for the field widths.
`timescale 1ns / 1ps

interface rsch_req_if import rsch_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [SLOT_W-1:0]        slot;
    logic                     obj_kind;
    logic [WIDX_W-1:0]        word_index;
    logic signed [WORD_W-1:0] word_value;
    logic signed [WORD_W-1:0] orig_x;
    logic signed [WORD_W-1:0] orig_y;
    logic signed [WORD_W-1:0] orig_z;
    logic signed [WORD_W-1:0] dir_x;
    logic signed [WORD_W-1:0] dir_y;
    logic signed [WORD_W-1:0] dir_z;

    modport source (output valid, req_type, slot, obj_kind, word_index, word_value,
                    orig_x, orig_y, orig_z, dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, req_type, slot, obj_kind, word_index, word_value,
                    orig_x, orig_y, orig_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface rsch_res_if import rsch_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DIST_W-1:0] distance;
    logic [SLOT_W-1:0] hit_slot;

    modport source (output valid, hit, distance, hit_slot, input ready);
    modport sink   (input valid, hit, distance, hit_slot, output ready);
endinterface

interface rsch_cfg_if import rsch_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/ray_scene_closest_hit.sv
// Closest-hit search of a ray against a table of triangles and spheres.
// Depends on rsch_pkg and on the channel interfaces in rsch_if.sv.
`timescale 1ns / 1ps

// Usage
//   req: one transfer is either a load (req_type 0) that writes one Q16.16 word
//   of an object slot and sets its kind, or a ray (req_type 1). A load
//   yields no result. A ray yields exactly one transfer on res.
//   cfg: register writes (object_count, det_epsilon, min_hit_distance) are taken
//   in any cycle and must only be issued while the block is idle.
// Datapath
//   The object table lives in a single-port word memory; each slot is fetched
//   word by word, then a shared 32x32 multiplier and accumulator step through a
//   micro-program, one product at a time. A triangle then runs a bit-serial
//   divider and a sphere a bit-serial square root; early misses skip them.
// Flow
//   req.ready is high only while no ray is being scanned. A finished result sits
//   in the output register; while res stalls, loads are still taken, and a new
//   ray scans but holds in its final state until the register frees.
// Reset
//   rst_n clears the control registers to their defaults and drops any pending result;
//   the object memory is not cleared and must be loaded before use.

module ray_scene_closest_hit
    import rsch_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rsch_req_if.sink   req,
    rsch_cfg_if.sink   cfg,
    rsch_res_if.source res
);

    // ------------------------------------------------------------------
    // Registers and storage
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [CNT_W-1:0]       count_reg;
    logic [CFG_DATA_W-1:0]  eps_reg;
    logic [CFG_DATA_W-1:0]  mhd_reg;

    logic [WORD_W-1:0]      word_mem [MEM_DEPTH];
    logic                   kind_mem [MAX_OBJECTS];
    logic [WORD_W-1:0]      rd_data_reg;
    logic                   kind_reg;

    logic signed [WORD_W-1:0] orig_reg [3];
    logic signed [WORD_W-1:0] dir_reg  [3];
    logic signed [WORD_W-1:0] w_reg    [WORDS_PER_OBJ];
    logic signed [WORD_W-1:0] t_reg    [3];
    logic signed [WORD_W-1:0] p_reg    [3];
    logic signed [WORD_W-1:0] q_reg    [3];
    logic signed [WORD_W-1:0] b_reg;

    logic signed [ACC_W-1:0] det_reg, un_reg, vn_reg, tn_reg, disc_reg;
    logic signed [ACC_W-1:0] prod_reg, acc_reg;
    logic [UPC_W-1:0]        upc_reg;

    logic [SCAN_W-1:0]     scan_n_reg;
    logic [SCAN_W-1:0]     slot_idx_reg;
    logic [ADDR_W-1:0]     base_reg;
    logic [FIDX_W-1:0]     fidx_reg;
    logic [STEP_W-1:0]     step_reg;

    logic [ACC_W-1:0]      den_reg;
    logic [ACC_W:0]        drem_reg;
    logic [DIST_W-1:0]     nbits_reg;
    logic [DIST_W-1:0]     quo_reg;

    logic [X_W-1:0]        x_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SREM_W-1:0]     srem_reg;

    logic                  found_reg;
    logic [DIST_W-1:0]     best_dist_reg;
    logic [SLOT_IDX_W-1:0] best_slot_reg;

    logic                  res_valid_reg;
    logic                  res_hit_reg;
    logic [DIST_W-1:0]     res_dist_reg;
    logic [SLOT_W-1:0]     res_slot_reg;

    // ------------------------------------------------------------------
    // Handshakes and load path
    // ------------------------------------------------------------------
    logic req_fire, ray_fire, load_fire, cfg_fire, res_fire;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign res_fire  = res.valid && res.ready;
    assign ray_fire  = req_fire && (req.req_type == REQ_RAY);
    // drop loads that address a slot or word outside the table
    assign load_fire = req_fire && (req.req_type == REQ_LOAD)
                       && (32'(req.slot) < MAX_OBJECTS)
                       && (32'(req.word_index) < WORDS_PER_OBJ);
    assign wr_addr   = ADDR_W'(32'(req.slot) * WORDS_PER_OBJ + 32'(req.word_index));
    assign rd_addr   = base_reg + ADDR_W'(fidx_reg);
    assign rd_en     = (state_reg == ST_FETCH) && (32'(fidx_reg) < WORDS_PER_OBJ);

    // Loads and scans never overlap: req is held off for the whole scan.
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            word_mem[wr_addr] <= req.word_value;
            kind_mem[SLOT_IDX_W'(req.slot)] <= req.obj_kind;
        end
        if (rd_en)
            rd_data_reg <= word_mem[rd_addr];
        if ((state_reg == ST_FETCH) && (fidx_reg == '0))
            kind_reg <= kind_mem[SLOT_IDX_W'(slot_idx_reg)];
    end

    // ------------------------------------------------------------------
    // Multiply-accumulate micro-step
    // ------------------------------------------------------------------
    ustep_t cur;
    logic signed [WORD_W-1:0]   op_a, op_b;
    logic signed [2*WORD_W-1:0] prod_full;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [WORD_W-1:0]   acc_sat;

    function automatic logic signed [WORD_W-1:0] pick(input opnd_t sel);
        logic signed [WORD_W-1:0] v;
        unique case (sel)
            OPND_W0: v = w_reg[0];
            OPND_W1: v = w_reg[1];
            OPND_W2: v = w_reg[2];
            OPND_W3: v = w_reg[3];
            OPND_W4: v = w_reg[4];
            OPND_W5: v = w_reg[5];
            OPND_W6: v = w_reg[6];
            OPND_W7: v = w_reg[7];
            OPND_W8: v = w_reg[8];
            OPND_W9: v = w_reg[9];
            OPND_D0: v = dir_reg[0];
            OPND_D1: v = dir_reg[1];
            OPND_D2: v = dir_reg[2];
            OPND_T0: v = t_reg[0];
            OPND_T1: v = t_reg[1];
            OPND_T2: v = t_reg[2];
            OPND_P0: v = p_reg[0];
            OPND_P1: v = p_reg[1];
            OPND_P2: v = p_reg[2];
            OPND_Q0: v = q_reg[0];
            OPND_Q1: v = q_reg[1];
            OPND_Q2: v = q_reg[2];
            OPND_B:  v = b_reg;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign cur       = ustep_rom(upc_reg);
    assign op_a      = pick(cur.a);
    assign op_b      = pick(cur.b);
    assign prod_full = op_a * op_b;

    always_comb
    begin
        case (cur.op)
            ACC_LOAD: acc_next = prod_reg;
            ACC_NEG:  acc_next = -prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            ACC_SUB:  acc_next = acc_reg - prod_reg;
            default:  acc_next = prod_reg;
        endcase
    end

    assign acc_sat = sat32(64'(acc_next));

    // ------------------------------------------------------------------
    // Triangle acceptance
    // ------------------------------------------------------------------
    logic                    det_neg;
    logic signed [ACC_W-1:0] mag, un_f, vn_f, tn_f;
    logic signed [ACC_W:0]   uv_sum;
    logic                    tri_fail, tri_sat;

    assign det_neg = det_reg < 0;
    assign mag     = det_neg ? -det_reg : det_reg;
    assign un_f    = det_neg ? -un_reg : un_reg;
    assign vn_f    = det_neg ? -vn_reg : vn_reg;
    assign tn_f    = det_neg ? -tn_reg : tn_reg;
    assign uv_sum  = (ACC_W+1)'(un_f) + (ACC_W+1)'(vn_f);
    // a zero determinant is parallel even when det_epsilon is zero
    assign tri_fail = (det_reg == 0) || (mag < $signed(ACC_W'(eps_reg)))
                      || (un_f < 0) || (un_f > mag)
                      || (vn_f < 0) || (uv_sum > (ACC_W+1)'(mag))
                      || (tn_f < 0);
    // integer part of the quotient too large: saturate the distance
    assign tri_sat  = 64'(tn_f) >= (64'(mag) <<< (DIST_W - FRAC_BITS));

    // ------------------------------------------------------------------
    // Divider and square root steps
    // ------------------------------------------------------------------
    logic [ACC_W:0]    drem_shift;
    logic              div_ge;
    logic [SREM_W-1:0] sq_shift, sq_trial;
    logic              sq_ge;

    assign drem_shift = {drem_reg[ACC_W-1:0], nbits_reg[DIST_W-1]};
    assign div_ge     = drem_shift >= {1'b0, den_reg};
    assign sq_shift   = {srem_reg[SREM_W-3:0], x_reg[X_W-1 -: 2]};
    assign sq_trial   = SREM_W'({root_reg, 2'b01});
    assign sq_ge      = sq_shift >= sq_trial;

    // ------------------------------------------------------------------
    // Sphere roots and best-hit update
    // ------------------------------------------------------------------
    logic signed [T_W-1:0] b_ext, s_ext, t_near, t_far, t_pick, mhd_t;
    logic                  near_ok, far_ok;
    logic [DIST_W-1:0]     sph_dist;
    logic                  cand_valid;
    logic [DIST_W-1:0]     cand_dist;
    logic                  upd;
    logic                  adv;

    assign b_ext    = T_W'(b_reg);
    assign s_ext    = $signed(T_W'(root_reg));
    assign mhd_t    = $signed(T_W'(mhd_reg));
    assign t_near   = b_ext - s_ext;
    assign t_far    = b_ext + s_ext;
    assign near_ok  = t_near >= mhd_t;
    assign far_ok   = t_far >= mhd_t;
    assign t_pick   = near_ok ? t_near : t_far;
    assign sph_dist = (t_pick > $signed(T_W'(DIST_MAX))) ? DIST_MAX : DIST_W'(t_pick);

    always_comb
    begin
        cand_valid = 1'b0;
        cand_dist  = quo_reg;
        if (state_reg == ST_DCHK)
            cand_valid = quo_reg >= DIST_W'(mhd_reg);
        else if (state_reg == ST_SPH_CHK)
        begin
            cand_valid = near_ok || far_ok;
            cand_dist  = sph_dist;
        end
    end

    // ties go to the lower slot: a later hit must be strictly nearer
    assign upd = cand_valid && (!found_reg || (cand_dist < best_dist_reg));
    assign adv = ((state_reg == ST_TRI_CHK) && tri_fail)
                 || (state_reg == ST_DCHK)
                 || ((state_reg == ST_SQ_INIT) && (disc_reg < 0))
                 || (state_reg == ST_SPH_CHK);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (ray_fire)
                    state_next = ST_SCAN;
            ST_SCAN:
                state_next = (slot_idx_reg == scan_n_reg) ? ST_OUT : ST_FETCH;
            ST_FETCH:
                if (32'(fidx_reg) == WORDS_PER_OBJ)
                    state_next = ST_TVEC;
            ST_TVEC:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
                if (cur.last)
                    state_next = (kind_reg == KIND_SPH) ? ST_SQ_INIT : ST_TRI_CHK;
                else
                    state_next = ST_MUL;
            ST_TRI_CHK:
                if (tri_fail)
                    state_next = ST_SCAN;
                else if (tri_sat)
                    state_next = ST_DCHK;
                else
                    state_next = ST_DIV;
            ST_DIV:
                if (step_reg == '0)
                    state_next = ST_DCHK;
            ST_DCHK:
                state_next = ST_SCAN;
            ST_SQ_INIT:
                state_next = (disc_reg < 0) ? ST_SCAN : ST_SQRT;
            ST_SQRT:
                if (step_reg == '0)
                    state_next = ST_SPH_CHK;
            ST_SPH_CHK:
                state_next = ST_SCAN;
            ST_OUT:
                if (!res_valid_reg || res.ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            eps_reg       <= CFG_DATA_W'(1);
            mhd_reg       <= CFG_DATA_W'(655);
            res_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            slot_idx_reg  <= '0;
            base_reg      <= '0;
            fidx_reg      <= '0;
            upc_reg       <= '0;
            step_reg      <= '0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg.index)
                    CFG_COUNT: count_reg <= cfg.data[CNT_W-1:0];
                    CFG_EPS:   eps_reg   <= cfg.data;
                    CFG_MHD:   mhd_reg   <= cfg.data;
                    default:   ;
                endcase
            end

            if ((state_reg == ST_OUT) && (state_next == ST_IDLE))
                res_valid_reg <= 1'b1;
            else if (res_fire)
                res_valid_reg <= 1'b0;

            if (ray_fire)
            begin
                found_reg    <= 1'b0;
                slot_idx_reg <= '0;
                base_reg     <= '0;
            end
            else if (adv)
            begin
                slot_idx_reg <= slot_idx_reg + SCAN_W'(1);
                base_reg     <= base_reg + ADDR_W'(WORDS_PER_OBJ);
            end
            if (upd)
                found_reg <= 1'b1;

            if (state_reg == ST_SCAN)
                fidx_reg <= '0;
            else if (state_reg == ST_FETCH)
                fidx_reg <= fidx_reg + FIDX_W'(1);

            if (state_reg == ST_TVEC)
                upc_reg <= (kind_reg == KIND_SPH) ? UPC_SPH : UPC_TRI;
            else if ((state_reg == ST_ACC) && !cur.last)
                upc_reg <= upc_reg + UPC_W'(1);

            if (state_reg == ST_TRI_CHK)
                step_reg <= STEP_W'(DIV_STEPS - 1);
            else if (state_reg == ST_SQ_INIT)
                step_reg <= STEP_W'(SQ_STEPS - 1);
            else if ((state_reg == ST_DIV) || (state_reg == ST_SQRT))
                step_reg <= step_reg - STEP_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ray_fire)
        begin
            orig_reg[0] <= req.orig_x;
            orig_reg[1] <= req.orig_y;
            orig_reg[2] <= req.orig_z;
            dir_reg[0]  <= req.dir_x;
            dir_reg[1]  <= req.dir_y;
            dir_reg[2]  <= req.dir_z;
            // scan no more slots than the table holds
            scan_n_reg  <= (32'(count_reg) > MAX_OBJECTS) ? SCAN_W'(MAX_OBJECTS)
                                                          : SCAN_W'(count_reg);
        end

        if (upd)
        begin
            best_dist_reg <= cand_dist;
            best_slot_reg <= SLOT_IDX_W'(slot_idx_reg);
        end

        if ((state_reg == ST_OUT) && (state_next == ST_IDLE))
        begin
            res_hit_reg  <= found_reg;
            res_dist_reg <= found_reg ? best_dist_reg : '0;
            res_slot_reg <= found_reg ? SLOT_W'(best_slot_reg) : '0;
        end

        unique case (state_reg)
            ST_FETCH:
                if (fidx_reg != '0)
                    w_reg[fidx_reg - FIDX_W'(1)] <= $signed(rd_data_reg);
            ST_TVEC:
                for (int i = 0; i < 3; i++)
                    t_reg[i] <= sat32(64'(orig_reg[i]) - 64'(w_reg[i]));
            ST_MUL:
                prod_reg <= ACC_W'(prod_full >>> FRAC_BITS);
            ST_ACC:
            begin
                acc_reg <= acc_next;
                unique case (cur.dst)
                    DST_NONE: ;
                    DST_P0:   p_reg[0] <= acc_sat;
                    DST_P1:   p_reg[1] <= acc_sat;
                    DST_P2:   p_reg[2] <= acc_sat;
                    DST_Q0:   q_reg[0] <= acc_sat;
                    DST_Q1:   q_reg[1] <= acc_sat;
                    DST_Q2:   q_reg[2] <= acc_sat;
                    DST_B:    b_reg    <= acc_sat;
                    DST_DET:  det_reg  <= acc_next;
                    DST_UN:   un_reg   <= acc_next;
                    DST_VN:   vn_reg   <= acc_next;
                    DST_TN:   tn_reg   <= acc_next;
                    DST_DISC: disc_reg <= acc_next;
                    default:  ;
                endcase
            end
            ST_TRI_CHK:
            begin
                // quotient of tn * 2^F by |det|, 31 bits, remainder starts below |det|
                den_reg   <= unsigned'(mag);
                drem_reg  <= (ACC_W+1)'(unsigned'(tn_f) >> (DIST_W - FRAC_BITS));
                nbits_reg <= DIST_W'(tn_f << FRAC_BITS);
                quo_reg   <= tri_sat ? DIST_MAX : '0;
            end
            ST_DIV:
            begin
                drem_reg  <= div_ge ? (drem_shift - {1'b0, den_reg}) : drem_shift;
                quo_reg   <= {quo_reg[DIST_W-2:0], div_ge};
                nbits_reg <= nbits_reg << 1;
            end
            ST_SQ_INIT:
            begin
                x_reg    <= X_W'(unsigned'(disc_reg)) << FRAC_BITS;
                srem_reg <= '0;
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                srem_reg <= sq_ge ? (sq_shift - sq_trial) : sq_shift;
                root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
                x_reg    <= x_reg << 2;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign res.valid    = res_valid_reg;
    assign res.hit      = res_hit_reg;
    assign res.distance = res_dist_reg;
    assign res.hit_slot = res_slot_reg;

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_hit_reg |-> (res_dist_reg == '0) && (res_slot_reg == '0))
        else $error("miss result carries a nonzero distance or slot");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (slot_idx_reg <= scan_n_reg)
                                   && (32'(scan_n_reg) <= MAX_OBJECTS))
        else $error("scan ran past the slot count");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (drem_reg < {1'b0, den_reg}))
        else $error("divider remainder not below the divisor");

    a_best_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) && found_reg |-> best_dist_reg >= DIST_W'(mhd_reg))
        else $error("best hit nearer than the minimum distance");
`endif

endmodule
